[rtl/sac_pkg.sv]
// Shared types, constants and helpers of the set-associative LRU cache tag store.
`timescale 1ns / 1ps
package sac_pkg;

    // default sizing
    localparam int DEF_MAX_SETS = 256;
    localparam int DEF_MAX_WAYS = 4;
    localparam int ADDR_WIDTH   = 32;

    // field widths
    localparam int CMD_W    = 1;
    localparam int ADDR_W   = 32;
    localparam int OP_W     = 32;
    localparam int TAG_W    = 32;
    localparam int SET_IDX_W = 8;
    localparam int WAY_OUT_W = 2;
    localparam int OUTC_W   = 2;
    localparam int COST_W   = 8;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_WIDTH >= ADDR_W) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    // commands
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register indexes
    localparam logic [1:0] REG_SET_BITS   = 2'd0;
    localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS       = 2'd2;

    // access cost
    localparam int MISS_PENALTY = 100;
    localparam logic [COST_W-1:0] COST_HIT   = COST_W'(1);
    localparam logic [COST_W-1:0] COST_CLEAN = COST_W'(MISS_PENALTY + 1);
    localparam logic [COST_W-1:0] COST_DIRTY = COST_W'(2 * MISS_PENALTY + 1);

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT        = 2'd0,
        OUT_CLEAN_MISS = 2'd1,
        OUT_DIRTY_MISS = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // sequencer -> way compare unit
    typedef struct packed {
        logic step;
        logic start;
    } t_scan_ctl;

    function automatic logic [COST_W-1:0] f_cost(input t_outcome outc);
        logic [COST_W-1:0] c;
        case (outc)
            OUT_HIT:        c = COST_HIT;
            OUT_CLEAN_MISS: c = COST_CLEAN;
            OUT_DIRTY_MISS: c = COST_DIRTY;
            default:        c = COST_HIT;
        endcase
        return c;
    endfunction

endpackage

[rtl/sac_ifs.sv]
// Request and response channel interfaces of the cache tag store.
`timescale 1ns / 1ps
interface sac_req_if;
    import sac_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] address;
    logic [OP_W-1:0]   op_index;

    modport source (output valid, command, address, op_index, input ready);
    modport sink   (input valid, command, address, op_index, output ready);
endinterface

interface sac_rsp_if;
    import sac_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [SET_IDX_W-1:0] set_idx;
    logic [TAG_W-1:0]     tag;
    logic [WAY_OUT_W-1:0] way;
    logic [OUTC_W-1:0]    outcome;
    logic [TAG_W-1:0]     victim_tag;
    logic                 victim_valid;
    logic                 victim_dirty;
    logic [OP_W-1:0]      last_op_index;
    logic [COST_W-1:0]    access_cost;

    modport source (output valid, set_idx, tag, way, outcome, victim_tag, victim_valid,
                    victim_dirty, last_op_index, access_cost, input ready);
    modport sink   (input valid, set_idx, tag, way, outcome, victim_tag, victim_valid,
                    victim_dirty, last_op_index, access_cost, output ready);
endinterface

[rtl/sac_mem.sv]
// Line store: one row per set holding tag, valid, dirty, rank and last op of every way.
`timescale 1ns / 1ps
module sac_mem import sac_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rd_en,
    input  logic [SET_W-1:0]                     i_rd_addr,
    output logic [MAX_WAYS-1:0][TAG_W-1:0]       o_rd_tags,
    output logic [MAX_WAYS-1:0]                  o_rd_valid,
    output logic [MAX_WAYS-1:0]                  o_rd_dirty,
    output logic [MAX_WAYS-1:0][WAY_W-1:0]       o_rd_rank,
    output logic [MAX_WAYS-1:0][OP_W-1:0]        o_rd_last,
    input  logic                                 i_wr_en,
    input  logic                                 i_wr_last_en,
    input  logic [SET_W-1:0]                     i_wr_addr,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]       i_wr_tags,
    input  logic [MAX_WAYS-1:0]                  i_wr_valid,
    input  logic [MAX_WAYS-1:0]                  i_wr_dirty,
    input  logic [MAX_WAYS-1:0][WAY_W-1:0]       i_wr_rank,
    input  logic [MAX_WAYS-1:0][OP_W-1:0]        i_wr_last
);

    logic [MAX_WAYS-1:0][TAG_W-1:0] r_mem_tags  [MAX_SETS];
    logic [MAX_WAYS-1:0]            r_mem_valid [MAX_SETS];
    logic [MAX_WAYS-1:0]            r_mem_dirty [MAX_SETS];
    logic [MAX_WAYS-1:0][WAY_W-1:0] r_mem_rank  [MAX_SETS];
    logic [MAX_WAYS-1:0][OP_W-1:0]  r_mem_last  [MAX_SETS];

    logic [MAX_WAYS-1:0][TAG_W-1:0] r_rd_tags;
    logic [MAX_WAYS-1:0]            r_rd_valid;
    logic [MAX_WAYS-1:0]            r_rd_dirty;
    logic [MAX_WAYS-1:0][WAY_W-1:0] r_rd_rank;
    logic [MAX_WAYS-1:0][OP_W-1:0]  r_rd_last;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_tags[i_wr_addr]  <= i_wr_tags;
            r_mem_valid[i_wr_addr] <= i_wr_valid;
            r_mem_dirty[i_wr_addr] <= i_wr_dirty;
            r_mem_rank[i_wr_addr]  <= i_wr_rank;
        end
        if (i_wr_last_en) begin
            r_mem_last[i_wr_addr] <= i_wr_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_tags  <= r_mem_tags[i_rd_addr];
            r_rd_valid <= r_mem_valid[i_rd_addr];
            r_rd_dirty <= r_mem_dirty[i_rd_addr];
            r_rd_rank  <= r_mem_rank[i_rd_addr];
            r_rd_last  <= r_mem_last[i_rd_addr];
        end
    end

    assign o_rd_tags  = r_rd_tags;
    assign o_rd_valid = r_rd_valid;
    assign o_rd_dirty = r_rd_dirty;
    assign o_rd_rank  = r_rd_rank;
    assign o_rd_last  = r_rd_last;

endmodule

[rtl/sac_way_cmp.sv]
// Shared way compare unit: one way per step, tag match and lowest-rank tracking.
`timescale 1ns / 1ps
module sac_way_cmp import sac_pkg::*; #(
    parameter int MAX_WAYS = DEF_MAX_WAYS,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [WAY_W-1:0] i_idx,
    input  logic             i_valid,
    input  logic [TAG_W-1:0] i_tag,
    input  logic [WAY_W-1:0] i_rank,
    input  logic [TAG_W-1:0] i_key,
    output logic             o_match,
    output logic             o_hit,
    output logic [WAY_W-1:0] o_way
);

    logic             r_hit;
    logic [WAY_W-1:0] r_way;
    logic [WAY_W-1:0] r_best_rank;
    logic             w_match;
    logic             w_lower;

    assign w_match = i_valid && (i_tag == i_key);
    // strict less: ties keep the lower-numbered way
    assign w_lower = i_rank < r_best_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.start) begin
                r_hit <= w_match;
            end else if (w_match) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            if (i_ctl.start || w_match || w_lower) begin
                r_way <= i_idx;
            end
            if (i_ctl.start || w_lower) begin
                r_best_rank <= i_rank;
            end
        end
    end

    assign o_match = w_match;
    assign o_hit   = r_hit;
    assign o_way   = r_way;

endmodule

[rtl/set_assoc_writeback_lru_cache_top.sv]
// Top level of the set-associative write-back LRU cache tag store.
// Usage:
//   Requests arrive on i_req (command, address, op_index); each produces exactly one
//   response on o_rsp. Both channels move a transaction on a clock edge where valid
//   and ready are both high. The APB port sets set_bits (0x0), block_bits (0x4) and
//   ways (0x8); pready is tied high. Write the registers only with no access outstanding.
// Timing:
//   One access at a time. After the request transaction the sequencer splits the address
//   and reads the set row, examines the ways one after another on the shared compare
//   unit (stopping at the first hit, so from one way up to all ways in use), then
//   writes the row back and loads the response register. The response turns valid
//   and i_req is ready again in that same cycle, so a new access is taken only after
//   the previous one has produced its response.
// Reset:
//   i_rst_n is synchronous, active low. Afterwards a clearing pass writes the reset
//   row to every set, one set per cycle, with i_req held not ready.
//   Register writes are accepted during the pass.
// Back-pressure:
//   A response held by o_rsp.ready stalls the row write-back of the next access in
//   its last cycle; nothing is dropped.
`timescale 1ns / 1ps
module set_assoc_writeback_lru_cache_top import sac_pkg::*; #(
    parameter int MAX_SETS = DEF_MAX_SETS,
    parameter int MAX_WAYS = DEF_MAX_WAYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sac_req_if.sink            i_req,
    sac_rsp_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CNT_W  = $clog2(MAX_WAYS + 1);
    localparam int MAX_SB = $clog2(MAX_SETS + 1) - 1;  // largest s with 2^s <= MAX_SETS

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [3:0] r_set_bits;
    logic [4:0] r_block_bits;
    logic [2:0] r_ways;
    logic       w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 4'd0;
            r_block_bits <= 5'd0;
            r_ways       <= 3'd1;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SET_BITS:   r_set_bits   <= pwdata[3:0];
                REG_BLOCK_BITS: r_block_bits <= pwdata[4:0];
                REG_WAYS:       r_ways       <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SET_BITS:   prdata = PDATA_W'(r_set_bits);
            REG_BLOCK_BITS: prdata = PDATA_W'(r_block_bits);
            REG_WAYS:       prdata = PDATA_W'(r_ways);
            default:        prdata = '0;
        endcase
    end

    // effective ways in use: 0 acts as 1, clamp to MAX_WAYS
    logic [CNT_W-1:0] w_ways_eff;
    logic [WAY_W-1:0] w_way_last;

    always_comb begin
        if (r_ways == 3'd0) begin
            w_ways_eff = CNT_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            w_ways_eff = CNT_W'(MAX_WAYS);
        end else begin
            w_ways_eff = CNT_W'(r_ways);
        end
    end
    assign w_way_last = WAY_W'(w_ways_eff - CNT_W'(1));

    // ------------------------------------------------------------------
    // captured request and address split
    // ------------------------------------------------------------------
    logic              r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [OP_W-1:0]   r_op;
    logic [SET_W-1:0]  r_set;
    logic [TAG_W-1:0]  r_tag;

    logic [3:0]        w_sb_eff;
    logic [5:0]        w_shift;
    logic [ADDR_W-1:0] w_addr_m;
    logic [ADDR_W-1:0] w_set_full;
    logic [SET_W-1:0]  w_set;
    logic [TAG_W-1:0]  w_tag;

    always_comb begin
        w_addr_m   = r_addr & ADDR_MASK;
        w_sb_eff   = (int'(r_set_bits) > MAX_SB) ? 4'(MAX_SB) : r_set_bits;
        w_shift    = 6'(w_sb_eff) + 6'(r_block_bits);
        // tag is zero once the shift covers the whole address
        w_tag      = (w_shift >= 6'(ADDR_W)) ? '0 : TAG_W'(w_addr_m >> w_shift[4:0]);
        w_set_full = (w_addr_m >> r_block_bits) & ~({ADDR_W{1'b1}} << w_sb_eff);
        w_set      = SET_W'(w_set_full);
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    t_state           r_state, n_state;
    logic [SET_W-1:0] r_clr_idx, n_clr_idx;
    logic [WAY_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             w_req_ready;
    logic             w_accept;
    logic             w_rd_en;
    logic             w_wr_en;
    logic             w_wr_last_en;
    logic [SET_W-1:0] w_wr_addr;
    logic             w_load_out;
    t_scan_ctl        w_scan_ctl;
    logic             w_match;
    logic             w_hit;
    logic [WAY_W-1:0] w_way;

    assign w_accept    = i_req.valid && w_req_ready;
    assign i_req.ready = w_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_idx        = r_idx;
        w_req_ready  = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_last_en = 1'b0;
        w_wr_addr    = r_set;
        w_load_out   = 1'b0;
        w_scan_ctl   = '0;
        case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_idx;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == SET_W'(MAX_SETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_req_ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                w_rd_en = 1'b1;
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                w_scan_ctl.step  = 1'b1;
                w_scan_ctl.start = (r_idx == '0);
                if (w_match || r_idx == w_way_last) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_UPDATE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_wr_en      = 1'b1;
                    w_wr_last_en = 1'b1;
                    w_load_out   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd  <= i_req.command;
            r_addr <= i_req.address;
            r_op   <= i_req.op_index;
        end
        if (r_state == ST_SPLIT) begin
            r_set <= w_set;
            r_tag <= w_tag;
        end
    end

    // ------------------------------------------------------------------
    // line store and shared compare unit
    // ------------------------------------------------------------------
    logic [MAX_WAYS-1:0][TAG_W-1:0] w_rd_tags, w_wr_tags, w_upd_tags;
    logic [MAX_WAYS-1:0]            w_rd_valid, w_wr_valid, w_upd_valid;
    logic [MAX_WAYS-1:0]            w_rd_dirty, w_wr_dirty, w_upd_dirty;
    logic [MAX_WAYS-1:0][WAY_W-1:0] w_rd_rank, w_wr_rank, w_upd_rank, w_rst_rank;
    logic [MAX_WAYS-1:0][OP_W-1:0]  w_rd_last, w_upd_last;

    sac_mem #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_mem (
        .i_clk        (i_clk),
        .i_rd_en      (w_rd_en),
        .i_rd_addr    (w_set),
        .o_rd_tags    (w_rd_tags),
        .o_rd_valid   (w_rd_valid),
        .o_rd_dirty   (w_rd_dirty),
        .o_rd_rank    (w_rd_rank),
        .o_rd_last    (w_rd_last),
        .i_wr_en      (w_wr_en),
        .i_wr_last_en (w_wr_last_en),
        .i_wr_addr    (w_wr_addr),
        .i_wr_tags    (w_wr_tags),
        .i_wr_valid   (w_wr_valid),
        .i_wr_dirty   (w_wr_dirty),
        .i_wr_rank    (w_wr_rank),
        .i_wr_last    (w_upd_last)
    );

    sac_way_cmp #(
        .MAX_WAYS (MAX_WAYS)
    ) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .i_idx   (r_idx),
        .i_valid (w_rd_valid[r_idx]),
        .i_tag   (w_rd_tags[r_idx]),
        .i_rank  (w_rd_rank[r_idx]),
        .i_key   (r_tag),
        .o_match (w_match),
        .o_hit   (w_hit),
        .o_way   (w_way)
    );

    // ------------------------------------------------------------------
    // row update: fill or mark dirty, then true-LRU touch
    // ------------------------------------------------------------------
    logic             w_v_valid;
    logic             w_v_dirty;
    logic [TAG_W-1:0] w_v_tag;
    logic [OP_W-1:0]  w_v_last;
    t_outcome         w_outcome;

    always_comb begin
        w_v_valid = w_rd_valid[w_way];
        w_v_dirty = w_rd_dirty[w_way];
        w_v_tag   = w_v_valid ? w_rd_tags[w_way] : '0;
        w_v_last  = w_v_valid ? w_rd_last[w_way] : '0;

        w_upd_tags  = w_rd_tags;
        w_upd_valid = w_rd_valid;
        w_upd_dirty = w_rd_dirty;
        w_upd_last  = w_rd_last;
        w_upd_last[w_way] = r_op;

        if (w_hit) begin
            w_outcome = OUT_HIT;
            if (r_cmd == CMD_WRITE) begin
                w_upd_dirty[w_way] = 1'b1;
            end
        end else begin
            w_outcome = (w_v_valid && w_v_dirty) ? OUT_DIRTY_MISS : OUT_CLEAN_MISS;
            w_upd_tags[w_way]  = r_tag;
            w_upd_valid[w_way] = 1'b1;
            w_upd_dirty[w_way] = (r_cmd == CMD_WRITE);
        end

        for (int j = 0; j < MAX_WAYS; j++) begin
            w_rst_rank[j] = WAY_W'(j);
            w_upd_rank[j] = w_rd_rank[j];
            if (j < int'(w_ways_eff)) begin
                if (WAY_W'(j) == w_way) begin
                    w_upd_rank[j] = w_way_last;
                end else if (w_rd_rank[j] > w_rd_rank[w_way]) begin
                    w_upd_rank[j] = w_rd_rank[j] - 1'b1;
                end
            end
        end

        if (r_state == ST_CLEAR) begin
            w_wr_tags  = '0;
            w_wr_valid = '0;
            w_wr_dirty = '0;
            w_wr_rank  = w_rst_rank;
        end else begin
            w_wr_tags  = w_upd_tags;
            w_wr_valid = w_upd_valid;
            w_wr_dirty = w_upd_dirty;
            w_wr_rank  = w_upd_rank;
        end
    end

    // ------------------------------------------------------------------
    // response register
    // ------------------------------------------------------------------
    logic [SET_IDX_W-1:0] r_o_set;
    logic [TAG_W-1:0]     r_o_tag;
    logic [WAY_OUT_W-1:0] r_o_way;
    t_outcome             r_o_outcome;
    logic [TAG_W-1:0]     r_o_vtag;
    logic                 r_o_vvalid;
    logic                 r_o_vdirty;
    logic [OP_W-1:0]      r_o_last;
    logic [COST_W-1:0]    r_o_cost;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_set     <= SET_IDX_W'(r_set);
            r_o_tag     <= r_tag;
            r_o_way     <= WAY_OUT_W'(w_way);
            r_o_outcome <= w_outcome;
            r_o_vtag    <= w_v_tag;
            r_o_vvalid  <= w_v_valid;
            r_o_vdirty  <= w_v_dirty;
            r_o_last    <= w_v_last;
            r_o_cost    <= f_cost(w_outcome);
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.set_idx       = r_o_set;
    assign o_rsp.tag           = r_o_tag;
    assign o_rsp.way           = r_o_way;
    assign o_rsp.outcome       = r_o_outcome;
    assign o_rsp.victim_tag    = r_o_vtag;
    assign o_rsp.victim_valid  = r_o_vvalid;
    assign o_rsp.victim_dirty  = r_o_vdirty;
    assign o_rsp.last_op_index = r_o_last;
    assign o_rsp.access_cost   = r_o_cost;

endmodule

[rtl/sac_chk.sv]
// Port-level assertion checker of the cache tag store, bound to the top level.
`timescale 1ns / 1ps
module sac_chk import sac_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [OUTC_W-1:0]   i_outcome,
    input logic [COST_W-1:0]   i_cost,
    input logic [TAG_W-1:0]    i_tag,
    input logic [TAG_W-1:0]    i_vtag,
    input logic                i_vvalid,
    input logic                i_vdirty,
    input logic [OP_W-1:0]     i_last
);

    // held response stays up
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // one access at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_outcome == OUT_HIT && i_cost == COST_HIT)
                     || (i_outcome == OUT_CLEAN_MISS && i_cost == COST_CLEAN)
                     || (i_outcome == OUT_DIRTY_MISS && i_cost == COST_DIRTY))
        else $error("cost does not match outcome");

    a_hit_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_outcome == OUT_HIT |-> i_vvalid && i_vtag == i_tag)
        else $error("hit on a line that does not hold the tag");

    // an invalid line is never dirty and carries no contents
    a_empty_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_vvalid |->
            i_vtag == '0 && i_last == '0 && !i_vdirty && i_outcome == OUT_CLEAN_MISS)
        else $error("invalid victim reported with contents");

endmodule

bind set_assoc_writeback_lru_cache_top sac_chk u_sac_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_outcome   (o_rsp.outcome),
    .i_cost      (o_rsp.access_cost),
    .i_tag       (o_rsp.tag),
    .i_vtag      (o_rsp.victim_tag),
    .i_vvalid    (o_rsp.victim_valid),
    .i_vdirty    (o_rsp.victim_dirty),
    .i_last      (o_rsp.last_op_index)
);

[dv/tb_set_assoc_writeback_lru_cache_top.sv]
// Self-checking testbench for the set-associative write-back LRU cache tag store.
`timescale 1ns / 1ps
module tb_set_assoc_writeback_lru_cache_top;
    import sac_pkg::*;

    localparam int NUM_SETS     = DEF_MAX_SETS;
    localparam int NUM_WAYS     = DEF_MAX_WAYS;
    localparam int SET_BITS_CAP = $clog2(NUM_SETS);
    // No transaction for this many cycles means the block is hung. Covers the
    // clearing pass after reset, the longest stall on each side and the drains.
    localparam int IDLE_LIMIT   = 5000;
    // Register slot past the last real register; writes there must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One response transaction, field for field.
    typedef struct packed {
        logic [SET_IDX_W-1:0] set_idx;
        logic [TAG_W-1:0]     tag;
        logic [WAY_OUT_W-1:0] way;
        t_outcome             outcome;
        logic [TAG_W-1:0]     victim_tag;
        logic                 victim_valid;
        logic                 victim_dirty;
        logic [OP_W-1:0]      last_op_index;
        logic [COST_W-1:0]    access_cost;
    } t_lookup;

    // Shadow copy of the tag store: predicts each lookup when the request is
    // accepted and holds the predictions until the responses come back in order.
    class lru_tag_tracker;
        logic [3:0]       cfg_set_bits;
        logic [4:0]       cfg_block_bits;
        logic [2:0]       cfg_ways;
        logic [TAG_W-1:0] shadow_tag[NUM_SETS][NUM_WAYS];
        bit               line_valid[NUM_SETS][NUM_WAYS];
        bit               line_dirty[NUM_SETS][NUM_WAYS];
        int unsigned      line_rank [NUM_SETS][NUM_WAYS];
        logic [OP_W-1:0]  line_op   [NUM_SETS][NUM_WAYS];
        t_lookup          expected_lookups[$];
        int unsigned      mismatches;

        function new();
            cfg_set_bits   = '0;
            cfg_block_bits = '0;
            cfg_ways       = 3'd1;
            mismatches     = 0;
            foreach (line_rank[s, w]) begin
                shadow_tag[s][w] = '0;
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_rank[s][w]  = w;
                line_op[s][w]    = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_SET_BITS:   cfg_set_bits   = value[3:0];
                REG_BLOCK_BITS: cfg_block_bits = value[4:0];
                REG_WAYS:       cfg_ways       = value[2:0];
                default: ;
            endcase
        endfunction

        // set_bits beyond what the store holds is clamped
        function int unsigned eff_set_bits();
            return (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : cfg_set_bits;
        endfunction

        // ways 0 acts as 1, anything above the store's ways as the maximum
        function int unsigned eff_ways();
            if (cfg_ways == 0) return 1;
            return (cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways;
        endfunction

        function void note_access(logic cmd, logic [ADDR_W-1:0] addr, logic [OP_W-1:0] op);
            t_lookup     r;
            logic [63:0] wide;
            int unsigned sbits, nways, shift, set, w, i;
            bit          hit;
            sbits = eff_set_bits();
            nways = eff_ways();
            shift = sbits + cfg_block_bits;
            wide  = {32'd0, addr & ADDR_MASK};
            r.tag = TAG_W'(wide >> shift);
            set   = int'((wide >> cfg_block_bits) & ((64'd1 << sbits) - 64'd1));
            w     = 0;
            hit   = 1'b0;
            for (i = 0; i < nways && !hit; i++) begin
                if (line_valid[set][i] && shadow_tag[set][i] == r.tag) begin
                    w   = i;
                    hit = 1'b1;
                end
            end
            // victim: lowest rank, lowest way number on a tie
            if (!hit) begin
                for (i = 1; i < nways; i++)
                    if (line_rank[set][i] < line_rank[set][w]) w = i;
            end
            r.set_idx       = SET_IDX_W'(set);
            r.way           = WAY_OUT_W'(w);
            r.victim_valid  = line_valid[set][w];
            r.victim_dirty  = line_dirty[set][w];
            r.victim_tag    = r.victim_valid ? shadow_tag[set][w] : '0;
            r.last_op_index = r.victim_valid ? line_op[set][w] : '0;
            if (hit) begin
                r.outcome     = OUT_HIT;
                r.access_cost = COST_HIT;
                if (cmd == CMD_WRITE) line_dirty[set][w] = 1'b1;
            end else begin
                if (r.victim_valid && r.victim_dirty) begin
                    r.outcome     = OUT_DIRTY_MISS;
                    r.access_cost = COST_DIRTY;
                end else begin
                    r.outcome     = OUT_CLEAN_MISS;
                    r.access_cost = COST_CLEAN;
                end
                shadow_tag[set][w] = r.tag;
                line_valid[set][w] = 1'b1;
                line_dirty[set][w] = (cmd == CMD_WRITE);
            end
            line_op[set][w] = op;
            // move the touched way to most recent, close the gap below it
            for (i = 0; i < nways; i++)
                if (i != w && line_rank[set][i] > line_rank[set][w]) line_rank[set][i]--;
            line_rank[set][w] = nways - 1;
            expected_lookups.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $error("%s: expected %0h, actual %0h", name, want, got);
            end
        endfunction

        function void check_response(t_lookup got);
            t_lookup want;
            if (expected_lookups.size() == 0) begin
                mismatches++;
                $error("response with no access outstanding");
                return;
            end
            want = expected_lookups.pop_front();
            compare_field("set_idx",       want.set_idx,       got.set_idx);
            compare_field("tag",           want.tag,           got.tag);
            compare_field("way",           want.way,           got.way);
            compare_field("outcome",       want.outcome,       got.outcome);
            compare_field("victim_tag",    want.victim_tag,    got.victim_tag);
            compare_field("victim_valid",  want.victim_valid,  got.victim_valid);
            compare_field("victim_dirty",  want.victim_dirty,  got.victim_dirty);
            compare_field("last_op_index", want.last_op_index, got.last_op_index);
            compare_field("access_cost",   want.access_cost,   got.access_cost);
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    sac_req_if req_if();
    sac_rsp_if rsp_if();

    lru_tag_tracker tag_tracker = new();

    // Idle controls: percent chance of a gap before each request (sender) or of a stall
    // starting on any unstalled cycle (receiver). quiet turns both off for the last part.
    int unsigned req_gap_pct   = 0;
    int unsigned rsp_stall_pct = 0;
    int unsigned stall_left    = 0;
    bit          quiet         = 1'b0;
    int unsigned idle_cycles   = 0;
    logic [31:0] tag_base      = '0;

    set_assoc_writeback_lru_cache_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Monitors run at the rising edge and see pre-edge values, so the order
    // against the block's own flops does not matter.
    always @(posedge i_clk) begin
        if (req_if.valid && req_if.ready)
            tag_tracker.note_access(req_if.command, req_if.address, req_if.op_index);
    end

    always @(posedge i_clk) begin : rsp_monitor
        t_lookup got;
        if (rsp_if.valid && rsp_if.ready) begin
            got.set_idx       = rsp_if.set_idx;
            got.tag           = rsp_if.tag;
            got.way           = rsp_if.way;
            got.outcome       = t_outcome'(rsp_if.outcome);
            got.victim_tag    = rsp_if.victim_tag;
            got.victim_valid  = rsp_if.victim_valid;
            got.victim_dirty  = rsp_if.victim_dirty;
            got.last_op_index = rsp_if.last_op_index;
            got.access_cost   = rsp_if.access_cost;
            tag_tracker.check_response(got);
        end
    end

    // Watchdog: any transaction or register access restarts the count.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Response back-pressure: random stall bursts, driven at the falling edge.
    initial begin
        rsp_if.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && !quiet && $urandom_range(0, 99) < rsp_stall_pct)
                stall_left = $urandom_range(1, 18);
            if (stall_left != 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    // Entered and left at a falling edge. valid stays high on exit so a
    // back-to-back request just overwrites the payload.
    task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr, logic [OP_W-1:0] op);
        if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        req_if.valid    = 1'b1;
        req_if.command  = cmd;
        req_if.address  = addr;
        req_if.op_index = op;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        tag_tracker.write_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Hold off new requests until every lookup has answered, then settle.
    task automatic drain(int unsigned settle);
        req_if.valid = 1'b0;
        while (tag_tracker.expected_lookups.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // Register writes only with the block idle, once drained and settled. Junk in the
    // upper data bits must be dropped.
    task automatic configure(logic [3:0] sbits, logic [4:0] bbits, logic [2:0] nways);
        drain(8);
        apb_write(REG_SET_BITS,   {28'($urandom()), sbits});
        apb_write(REG_BLOCK_BITS, {27'($urandom()), bbits});
        apb_write(REG_WAYS,       {29'($urandom()), nways});
        if ($urandom_range(0, 1) == 0) apb_write(REG_UNUSED, $urandom());
    endtask

    // Mostly addresses built from a small tag pool over a few sets, so lines
    // hit, fill, age and get evicted; the rest are fully random addresses.
    task automatic random_access();
        logic [63:0] a;
        logic [63:0] set_sel;
        int unsigned sbits, bbits;
        sbits = tag_tracker.eff_set_bits();
        bbits = tag_tracker.cfg_block_bits;
        if ($urandom_range(0, 99) < 20) begin
            a = {32'd0, $urandom()};
        end else begin
            set_sel = ($urandom_range(0, 9) == 0) ? 64'($urandom()) : 64'($urandom_range(0, 3));
            a = (64'(tag_base + $urandom_range(0, 5)) << (sbits + bbits))
              | ((set_sel & ((64'd1 << sbits) - 64'd1)) << bbits)
              | (64'($urandom()) & ((64'd1 << bbits) - 64'd1));
        end
        send_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, a[31:0], $urandom());
    endtask

    task automatic run_phase(logic [3:0] sbits, logic [4:0] bbits, logic [2:0] nways,
                             int unsigned count);
        int unsigned k;
        configure(sbits, bbits, nways);
        tag_base      = $urandom();
        req_gap_pct   = 15 * $urandom_range(0, 3);
        rsp_stall_pct = 15 * $urandom_range(0, 3);
        for (k = 0; k < count; k++) begin
            // sender waits for every outstanding lookup once per phase
            if (k == count / 2) drain(0);
            random_access();
        end
    endtask

    initial begin
        int unsigned t;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        req_if.valid    = 1'b0;
        req_if.command  = CMD_READ;
        req_if.address  = '0;
        req_if.op_index = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, one direct-mapped line: fill from invalid, write hit
        // makes it dirty, then a conflicting access forces a dirty eviction.
        send_access(CMD_READ,  32'h0000_0000, 32'h0000_0000);
        send_access(CMD_WRITE, 32'h0000_0000, 32'h0000_0001);
        send_access(CMD_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_access(CMD_WRITE, 32'hFFFF_FFFF, 32'h0000_0002);
        send_access(CMD_READ,  32'h5555_AAAA, 32'h0000_0003);

        // Four sets, 16-byte blocks, four ways: fill set 1, touch two lines,
        // then push new tags through so the LRU order picks the victims.
        configure(4'd2, 5'd4, 3'd4);
        for (t = 1; t <= 4; t++) send_access(CMD_READ, (t << 6) | 32'h10, t);
        send_access(CMD_READ,  (32'd1 << 6) | 32'h1F, 32'h10);
        send_access(CMD_WRITE, (32'd2 << 6) | 32'h10, 32'h11);
        for (t = 5; t <= 7; t++) send_access(CMD_READ, (t << 6) | 32'h10, t);
        send_access(CMD_WRITE, (32'd8 << 6) | 32'h10, 32'h12);

        // Shrinking ways leaves stale ranks behind; 0 ways acts as one.
        configure(4'd2, 5'd4, 3'd2);
        send_access(CMD_READ,  (32'd9 << 6) | 32'h10, 32'h20);
        send_access(CMD_WRITE, (32'd8 << 6) | 32'h10, 32'h21);
        configure(4'd2, 5'd4, 3'd0);
        send_access(CMD_READ, (32'd10 << 6) | 32'h10, 32'h22);

        // Oversized set bits clamp, huge block offset leaves a zero tag,
        // ways above the store's size act as the maximum.
        configure(4'd15, 5'd31, 3'd7);
        send_access(CMD_READ,  32'h8000_0000, 32'h30);
        send_access(CMD_WRITE, 32'h7FFF_FFFF, 32'h31);
        configure(4'd8, 5'd16, 3'd4);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_access(CMD_READ, 32'hFFFF_FFFF, 32'h32);
        send_access(CMD_READ, 32'h0000_0000, 32'h33);

        // Random part over a spread of settings, extremes included.
        run_phase(4'd0,  5'd0,  3'd1, 120);
        run_phase(4'd8,  5'd4,  3'd4, 120);
        run_phase(4'd15, 5'd31, 3'd7, 120);
        run_phase(4'd3,  5'd2,  3'd2, 120);
        run_phase(4'd1,  5'd16, 3'd0, 120);
        run_phase(4'd8,  5'd0,  3'd3, 120);
        run_phase(4'd5,  5'd6,  3'd5, 120);
        run_phase(4'd2,  5'd3,  3'd4, 120);
        run_phase(4'd0,  5'd5,  3'd4, 120);
        repeat (3) run_phase(4'($urandom_range(0, 15)), 5'($urandom_range(0, 9)),
                             3'($urandom_range(0, 7)), 120);

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        run_phase(4'd4, 5'd3, 3'd4, 150);

        drain(20);
        if (tag_tracker.mismatches == 0 && tag_tracker.expected_lookups.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
